// ===== sv/rstm_pkg.sv =====
// Shared constants, register codes and sine table math for the tone mixer.
`timescale 1ns / 1ps
`default_nettype none

package rstm_pkg;

  // Configuration register indexes
  localparam logic [7:0] CFG_TONE_LEVEL      = 8'd0;
  localparam logic [7:0] CFG_RAMP_STEP       = 8'd1;
  localparam logic [7:0] CFG_INCREMENT_LIMIT = 8'd2;
  localparam logic [7:0] CFG_STEREO          = 8'd3;

  // Reset values
  localparam logic [15:0] TONE_LEVEL_RST      = 16'd4135;
  localparam logic [15:0] RAMP_STEP_RST       = 16'd17;
  localparam logic [31:0] INCREMENT_LIMIT_RST = 32'd2104533975;
  localparam logic        STEREO_RST          = 1'b1;
  localparam logic [31:0] HELD_INCREMENT_RST  = 32'd39370534;

  // Sine table: quarter wave, magnitude in Q1.23 (sign bit never stored)
  localparam int          SINE_W      = 23;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] SINE_MAX    = 64'd8388607;

  // Taylor series of sin(x), x in Q2.30, truncating products, result Q1.23
  function automatic logic [SINE_W-1:0] sine_q23(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
    term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
    term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
    v = (sum + 64'd64) >> 7;
    if (v > SINE_MAX) begin
      v = SINE_MAX;
    end
    return v[SINE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/rstm_sine_rom.sv =====
// Quarter-wave sine ROM built at elaboration, registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rstm_sine_rom
  import rstm_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [AW-1:0]     addr_i,
  output logic      [SINE_W-1:0] data_o
);

  logic [SINE_W-1:0] rom [DEPTH];

  // entry i = sin((2i+1) * pi / (4 * DEPTH))
  for (genvar g = 0; g < DEPTH; g++) begin : g_entry
    localparam logic [63:0] X =
      (64'(2 * g + 1) * HALF_PI_Q30 + 64'(DEPTH)) / (64'(2) * 64'(DEPTH));
    localparam logic [SINE_W-1:0] ENTRY = sine_q23(X);
    assign rom[g] = ENTRY;
  end

  // registered read, held while the stage is stalled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_o <= rom[addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/ramped_sine_tone_mixer_core.sv =====
// Top level: ramped sine tone added to a stereo stream, three-stage pipeline.
// Stages from input accept to result valid: ROM read, multiply, mix.
// Throughput: one item per cycle while the output is not stalled; phase and amplitude update in the accept cycle.
// Ready ripples back per stage, so bubbles fill while a result waits.
// Reset (async, active low): pipeline empty, phase 0, amplitude 0, registers
// at their default values, held increment 440 Hz at 48 kHz.
`timescale 1ns / 1ps
`default_nettype none

module ramped_sine_tone_mixer_core
  import rstm_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int SAMPLE_WIDTH     = 24,
  parameter int PHASE_WIDTH      = 32,
  localparam int IN_W  = ((2 * SAMPLE_WIDTH + 32 + 7) / 8) * 8,
  localparam int OUT_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // input item: in_left, in_right, tone_increment (from bit 0 up)
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  // result item: out_left, out_right (from bit 0 up)
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [OUT_W-1:0] m_axis_tdata,
  // result flag: active
  output logic      [0:0]       m_axis_tuser,
  // configuration write channel
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [7:0]       cfg_index_i,
  input  wire logic [31:0]      cfg_data_i
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int PW  = PHASE_WIDTH;
  localparam int AW  = $clog2(SINE_TABLE_DEPTH);
  localparam int MW  = PW - 2 + AW + 1;
  localparam int UP  = (PW >= 32) ? PW - 32 : 0;
  localparam int DN  = (PW >= 32) ? 0 : 32 - PW;
  localparam int PRW = SINE_W + 16;
  localparam int RSH = 40 - SW;

  // ---------------- configuration registers ----------------
  logic [15:0] tone_level_q;
  logic [15:0] ramp_step_q;
  logic [31:0] inc_limit_q;
  logic        stereo_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_level_q <= TONE_LEVEL_RST;
      ramp_step_q  <= RAMP_STEP_RST;
      inc_limit_q  <= INCREMENT_LIMIT_RST;
      stereo_q     <= STEREO_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_TONE_LEVEL:      tone_level_q <= cfg_data_i[15:0];
        CFG_RAMP_STEP:       ramp_step_q  <= cfg_data_i[15:0];
        CFG_INCREMENT_LIMIT: inc_limit_q  <= cfg_data_i;
        CFG_STEREO:          stereo_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- stage handshake ----------------
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  logic in_acc;

  assign rdy3          = !v3_q || m_axis_tready;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;
  assign in_acc        = s_axis_tvalid && rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // ---------------- accept: tone state update ----------------
  logic [SW-1:0] in_left, in_right;
  logic [31:0]   tone_inc;

  assign in_left  = s_axis_tdata[SW-1:0];
  assign in_right = s_axis_tdata[2*SW-1:SW];
  assign tone_inc = s_axis_tdata[2*SW+31:2*SW];

  logic [PW-1:0] phase_q, phase_d;
  logic [15:0]   amp_q, amp_d;
  logic [31:0]   held_inc_q, held_inc_d;
  logic          inc_ok;
  logic          active;
  logic          sounding;
  logic [15:0]   target;
  logic signed [17:0] diff;
  logic signed [17:0] step_s;
  logic [PW+31:0] inc_ext;
  logic [PW-1:0]  inc_scaled;

  always_comb begin
    inc_ok     = (tone_inc != 32'd0) && (tone_inc < inc_limit_q);
    target     = inc_ok ? tone_level_q : 16'd0;
    active     = inc_ok || (amp_q != 16'd0);
    sounding   = (target != 16'd0) || (amp_q != 16'd0);
    held_inc_d = inc_ok ? tone_inc : held_inc_q;

    // slew toward target, at most one step per item
    step_s = $signed({2'b00, ramp_step_q});
    diff   = $signed({2'b00, target}) - $signed({2'b00, amp_q});
    if (diff > step_s) begin
      diff = step_s;
    end
    if (diff < -step_s) begin
      diff = -step_s;
    end

    // held increment scaled to the phase width
    inc_ext    = (PW + 32)'(held_inc_d);
    inc_ext    = (inc_ext << UP) >> DN;
    inc_scaled = inc_ext[PW-1:0];

    amp_d   = amp_q;
    phase_d = phase_q;
    if (sounding) begin
      amp_d   = 16'($signed({2'b00, amp_q}) + diff);
      phase_d = phase_q + inc_scaled;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= '0;
      amp_q      <= 16'd0;
      held_inc_q <= HELD_INCREMENT_RST;
    end else if (in_acc) begin
      phase_q    <= phase_d;
      amp_q      <= amp_d;
      held_inc_q <= held_inc_d;
    end
  end

  // table address from the phase before the advance
  logic [1:0]    quad;
  logic [MW-1:0] idx_prod;
  logic [AW-1:0] idx;
  logic [AW-1:0] rom_addr;

  always_comb begin
    quad     = phase_q[PW-1 -: 2];
    idx_prod = MW'(phase_q[PW-3:0]) * MW'(SINE_TABLE_DEPTH);
    idx      = idx_prod[PW-2 +: AW];
    rom_addr = quad[0] ? (AW'(SINE_TABLE_DEPTH - 1) - idx) : idx;
  end

  // ---------------- stage 1: table read ----------------
  logic [SINE_W-1:0] sine_mag;

  rstm_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH),
    .AW    (AW)
  ) u_rom (
    .clk_i  (clk_i),
    .en_i   (rdy1),
    .addr_i (rom_addr),
    .data_o (sine_mag)
  );

  logic [SW-1:0] s1_left_q, s1_right_q;
  logic [15:0]   s1_amp_q;
  logic          s1_neg_q;
  logic          s1_active_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_left_q   <= in_left;
      s1_right_q  <= in_right;
      s1_amp_q    <= amp_d;
      s1_neg_q    <= quad[1];
      s1_active_q <= active;
    end
  end

  // ---------------- stage 2: magnitude times amplitude ----------------
  logic [SW-1:0]  s2_left_q, s2_right_q;
  logic [PRW-1:0] s2_mag_q;
  logic           s2_neg_q;
  logic           s2_active_q;

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      s2_left_q   <= s1_left_q;
      s2_right_q  <= s1_right_q;
      s2_mag_q    <= PRW'(sine_mag) * PRW'(s1_amp_q);
      s2_neg_q    <= s1_neg_q;
      s2_active_q <= s1_active_q;
    end
  end

  // ---------------- stage 3: round, mix, saturate ----------------
  function automatic logic [SW-1:0] sat_sample(input logic signed [SW+1:0] v);
    logic signed [SW+1:0] hi;
    logic signed [SW+1:0] lo;
    hi = (SW + 2)'((64'd1 << (SW - 1)) - 64'd1);
    lo = -hi - (SW + 2)'(1);
    if (v > hi) begin
      return hi[SW-1:0];
    end else if (v < lo) begin
      return lo[SW-1:0];
    end
    return v[SW-1:0];
  endfunction

  logic [40:0]          rnd_sum;
  logic [SW-1:0]        tone_mag;
  logic signed [SW:0]   tone;
  logic signed [SW+1:0] mix_l, mix_r;
  logic [SW-1:0]        out_left_d, out_right_d;

  always_comb begin
    rnd_sum  = 41'(s2_mag_q) + (41'd1 << (RSH - 1));
    tone_mag = SW'(rnd_sum >> RSH);
    tone     = s2_neg_q ? -$signed({1'b0, tone_mag}) : $signed({1'b0, tone_mag});
    mix_l    = (SW + 2)'($signed(s2_left_q)) + (SW + 2)'(tone);
    mix_r    = (SW + 2)'($signed(s2_right_q));
    if (stereo_q) begin
      mix_r = mix_r + (SW + 2)'(tone);
    end
    out_left_d  = sat_sample(mix_l);
    out_right_d = sat_sample(mix_r);
  end

  logic [SW-1:0] out_left_q, out_right_q;
  logic          out_active_q;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      out_left_q   <= out_left_d;
      out_right_q  <= out_right_d;
      out_active_q <= s2_active_q;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = OUT_W'({out_right_q, out_left_q});
  assign m_axis_tuser  = out_active_q;

endmodule

`default_nettype wire

// ===== sv/rstm_checker.sv =====
// Port-level checks for the tone mixer core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rstm_checker #(
  parameter int OUT_W = 48
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata,
  input wire logic [0:0]       m_axis_tuser
);

  // items inside the pipeline
  logic [2:0] occ_q;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 3'd0;
    end else begin
      occ_q <= occ_q + 3'(in_acc) - 3'(out_acc);
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // empty output stage means the pipeline can take an item
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with output stage empty");

  // never more items in flight than stages
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= 3'd3)
    else $error("more than three items in flight");

  // a result only shows for an accepted item
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> occ_q != 3'd0)
    else $error("result without accepted item");

endmodule

bind ramped_sine_tone_mixer_core rstm_checker #(
  .OUT_W (OUT_W)
) u_rstm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
